/* rtl/assert_macros.svh */
// Assertion macros for self-checking RTL, used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/rgb2hsv_pkg.sv */
// Types, constants and helpers shared by the RGB to HSV converter.
`timescale 1ns / 1ps
package rgb2hsv_pkg;

	localparam int CH_W      = 8;   // channel width
	localparam int NUM_W     = 16;  // dividend width
	localparam int Q_W       = 8;   // quotient bits, one per divider stage
	localparam int SAT_SCALE = 255;
	localparam int HUE_SCALE = 43;
	localparam int OFS_RED   = 0;
	localparam int OFS_GREEN = 85;
	localparam int OFS_BLUE  = 171;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
	} hsv_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Sideband that rides along with the divisions.
	typedef struct packed {
		sector_t         sector;
		logic            neg;        // hue difference is negative
		logic            gray;       // max == min, hue and sat forced to 0
		logic [CH_W-1:0] brightness;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] sat_num;
		logic [CH_W-1:0]  sat_den;
		logic [NUM_W-1:0] hue_num;
		logic [CH_W-1:0]  hue_den;
		side_t            side;
	} div_in_t;

	typedef struct packed {
		logic [Q_W-1:0] sat_q;
		logic [Q_W-1:0] hue_q;
		side_t          side;
	} div_out_t;

	function automatic logic [CH_W-1:0] sector_offset(sector_t sec);
		logic [CH_W-1:0] ofs;
		unique case (sec)
			SEC_RED:   ofs = CH_W'(OFS_RED);
			SEC_GREEN: ofs = CH_W'(OFS_GREEN);
			SEC_BLUE:  ofs = CH_W'(OFS_BLUE);
			default:   ofs = CH_W'(OFS_RED);
		endcase
		return ofs;
	endfunction

endpackage

/* rtl/rgb2hsv_prep.sv */
// Front end: max/min and sector pick, then dividends for saturation and hue.
`timescale 1ns / 1ps
module rgb2hsv_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_stall,
	input  rgb2hsv_pkg::pixel_t  up_word,
	output logic                 dn_valid,
	input  logic                 dn_stall,
	output rgb2hsv_pkg::div_in_t dn_word
);
	import rgb2hsv_pkg::*;

	logic            valid_s1, valid_s2;
	logic            hold_s1, hold_s2;
	logic [CH_W-1:0] mx_s1, mn_s1, p_s1, n_s1;
	sector_t         sec_s1;
	div_in_t         word_s2;

	logic            r_max, g_max;
	logic [CH_W-1:0] mx, mn, p, n;
	sector_t         sec;
	logic [CH_W-1:0] delta, mag;
	logic            neg;
	div_in_t         nxt2;

	assign hold_s2  = valid_s2 && dn_stall;
	assign hold_s1  = valid_s1 && hold_s2;
	assign up_stall = hold_s1;

	// Stage 1: ties go to red, then green.
	always_comb begin
		r_max = (up_word.red >= up_word.green) && (up_word.red >= up_word.blue);
		g_max = !r_max && (up_word.green >= up_word.blue);
		mn = (up_word.red < up_word.green) ? up_word.red : up_word.green;
		mn = (up_word.blue < mn) ? up_word.blue : mn;
		if (r_max) begin
			sec = SEC_RED;
			mx  = up_word.red;
			p   = up_word.green;
			n   = up_word.blue;
		end else if (g_max) begin
			sec = SEC_GREEN;
			mx  = up_word.green;
			p   = up_word.blue;
			n   = up_word.red;
		end else begin
			sec = SEC_BLUE;
			mx  = up_word.blue;
			p   = up_word.red;
			n   = up_word.green;
		end
	end

	// Stage 2: differences and scaled dividends.
	always_comb begin
		delta = mx_s1 - mn_s1;
		neg   = p_s1 < n_s1;
		mag   = neg ? (n_s1 - p_s1) : (p_s1 - n_s1);
		nxt2.sat_num = NUM_W'(delta) * NUM_W'(SAT_SCALE);
		nxt2.sat_den = mx_s1;
		nxt2.hue_num = NUM_W'(mag) * NUM_W'(HUE_SCALE);
		nxt2.hue_den = delta;
		nxt2.side.sector     = sec_s1;
		nxt2.side.neg        = neg;
		nxt2.side.gray       = (delta == '0);
		nxt2.side.brightness = mx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!hold_s1) valid_s1 <= up_valid;
			if (!hold_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s1) begin
			mx_s1  <= mx;
			mn_s1  <= mn;
			p_s1   <= p;
			n_s1   <= n;
			sec_s1 <= sec;
		end
		if (!hold_s2) word_s2 <= nxt2;
	end

	assign dn_valid = valid_s2;
	assign dn_word  = word_s2;
endmodule

/* rtl/rgb2hsv_div.sv */
// Twin restoring dividers, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module rgb2hsv_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_stall,
	input  rgb2hsv_pkg::div_in_t  up_word,
	output logic                  dn_valid,
	input  logic                  dn_stall,
	output rgb2hsv_pkg::div_out_t dn_word
);
	import rgb2hsv_pkg::*;

	typedef struct packed {
		logic [NUM_W-1:0] sat_rem;
		logic [CH_W-1:0]  sat_den;
		logic [Q_W-1:0]   sat_q;
		logic [NUM_W-1:0] hue_rem;
		logic [CH_W-1:0]  hue_den;
		logic [Q_W-1:0]   hue_q;
		side_t            side;
	} div_stage_t;

	div_stage_t         cur [Q_W+1];
	div_stage_t         nxt [Q_W];
	div_stage_t         stage_s [Q_W];
	logic [Q_W-1:0]     valid_s;
	logic [Q_W-1:0]     hold;

	assign cur[0] = '{
		sat_rem: up_word.sat_num,
		sat_den: up_word.sat_den,
		sat_q:   '0,
		hue_rem: up_word.hue_num,
		hue_den: up_word.hue_den,
		hue_q:   '0,
		side:    up_word.side
	};

	assign up_stall = hold[0];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int BIT = Q_W - 1 - k;

		logic [NUM_W-1:0] sat_sh, hue_sh;
		logic             sat_ge, hue_ge;

		if (k == Q_W - 1) begin : g_last
			assign hold[k] = valid_s[k] && dn_stall;
		end else begin : g_mid
			assign hold[k] = valid_s[k] && hold[k+1];
		end

		always_comb begin
			sat_sh = NUM_W'(cur[k].sat_den) << BIT;
			hue_sh = NUM_W'(cur[k].hue_den) << BIT;
			sat_ge = cur[k].sat_rem >= sat_sh;
			hue_ge = cur[k].hue_rem >= hue_sh;
			nxt[k] = cur[k];
			if (sat_ge) begin
				nxt[k].sat_rem    = cur[k].sat_rem - sat_sh;
				nxt[k].sat_q[BIT] = 1'b1;
			end
			if (hue_ge) begin
				nxt[k].hue_rem    = cur[k].hue_rem - hue_sh;
				nxt[k].hue_q[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (!hold[k]) begin
				valid_s[k] <= (k == 0) ? up_valid : valid_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (!hold[k]) stage_s[k] <= nxt[k];
		end

		assign cur[k+1] = stage_s[k];
	end

	assign dn_valid      = valid_s[Q_W-1];
	assign dn_word.sat_q = cur[Q_W].sat_q;
	assign dn_word.hue_q = cur[Q_W].hue_q;
	assign dn_word.side  = cur[Q_W].side;
endmodule

/* rtl/rgb2hsv_post.sv */
// Back end: sector offset plus signed quotient, gray forcing, output register.
`timescale 1ns / 1ps
module rgb2hsv_post (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_stall,
	input  rgb2hsv_pkg::div_out_t up_word,
	output logic                  dn_valid,
	input  logic                  dn_stall,
	output rgb2hsv_pkg::hsv_t     dn_word
);
	import rgb2hsv_pkg::*;

	logic            valid_q;
	logic            hold;
	hsv_t            word_q;
	hsv_t            nxt;
	logic [CH_W-1:0] ofs;

	assign hold     = valid_q && dn_stall;
	assign up_stall = hold;

	always_comb begin
		ofs = sector_offset(up_word.side.sector);
		nxt.brightness = up_word.side.brightness;
		if (up_word.side.gray) begin
			nxt.hue        = '0;
			nxt.saturation = '0;
		end else begin
			nxt.saturation = up_word.sat_q;
			// hue wraps mod 256
			nxt.hue = up_word.side.neg ? (ofs - up_word.hue_q) : (ofs + up_word.hue_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!hold) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) word_q <= nxt;
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;
endmodule

/* rtl/rgb_to_hsv_converter.sv */
// RGB to HSV converter: 8-bit pixel in, 8-bit hue, saturation and value out.
//
// Takes one pixel word per clock while pixel_stall is low and returns one
// HSV word per pixel, in order. From input accept to output valid a pixel
// passes two front-end stages (max/min/sector, then channel differences and
// the dividends 255*(max-min) and 43*|diff|), eight divider stages that each
// settle one quotient bit for saturation and hue side by side, and one output
// register that adds the sector offset (0, 85, 171) and wraps hue mod 256.
// Throughput is one pixel per cycle while hsv_stall stays low. Every stage
// keeps its own valid bit and holds only while it is full and the stage after
// it holds, so bubbles get squeezed out under backpressure and pixel_stall
// rises only when every stage holds a word. Gray and black pixels give hue
// and saturation of zero; ties for the max go to red, then green.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgb_to_hsv_converter (
	input  logic                clk,
	input  logic                arst_n,
	// pixel side
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  rgb2hsv_pkg::pixel_t pixel,
	// HSV side
	output logic                hsv_valid,
	input  logic                hsv_stall,
	output rgb2hsv_pkg::hsv_t   hsv
);
	import rgb2hsv_pkg::*;

	logic     prep_valid, prep_stall;
	div_in_t  prep_word;
	logic     div_valid, div_stall;
	div_out_t div_word;

	rgb2hsv_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pixel_valid),
		.up_stall (pixel_stall),
		.up_word  (pixel),
		.dn_valid (prep_valid),
		.dn_stall (prep_stall),
		.dn_word  (prep_word)
	);

	rgb2hsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (prep_valid),
		.up_stall (prep_stall),
		.up_word  (prep_word),
		.dn_valid (div_valid),
		.dn_stall (div_stall),
		.dn_word  (div_word)
	);

	rgb2hsv_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid),
		.up_stall (div_stall),
		.up_word  (div_word),
		.dn_valid (hsv_valid),
		.dn_stall (hsv_stall),
		.dn_word  (hsv)
	);

	// Backpressure at the input can only come from a stalled output.
	`ASSERT_IMPLIES(a_stall_origin, pixel_stall, hsv_valid && hsv_stall, "input stall without output stall")
	// Black pixel gives zero hue and saturation.
	`ASSERT_IMPLIES(a_black, hsv_valid && (hsv.brightness == '0), (hsv.hue == '0) && (hsv.saturation == '0), "black pixel with nonzero hue or saturation")
	// Zero saturation means zero hue.
	`ASSERT_IMPLIES(a_gray, hsv_valid && (hsv.saturation == '0), hsv.hue == '0, "gray pixel with nonzero hue")
	// Saturation above zero only from a full divider word with a nonzero max.
	`ASSERT_IMPLIES(a_sat_src, div_valid && !div_word.side.gray, div_word.side.brightness != '0, "colored word with zero brightness")
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the RGB to HSV converter: directed corners plus random pixels.
`timescale 1ns / 1ps
module testbench;
	import rgb2hsv_pkg::*;

	// Pipeline depth from accept to output valid.
	localparam int PIPE_LATENCY = 11;
	// Cycles with no word moving on either side before the run is declared hung.
	localparam int STUCK_LIMIT  = 4000;
	localparam int RANDOM_WORDS = 130;  // per idling profile

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   pixel_valid = 1'b0;
	logic   pixel_stall;
	pixel_t pixel       = '0;
	logic   hsv_valid;
	logic   hsv_stall   = 1'b0;
	hsv_t   hsv;

	// Expected HSV words, oldest first, pushed as pixels are accepted.
	hsv_t expected_hsv[$];
	int   mismatches   = 0;
	int   pixels_in    = 0;
	int   words_out    = 0;

	// Idling profile, changed between phases by the stimulus.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	rgb_to_hsv_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hsv        (hsv)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Sector offset plus 43*(lead-trail)/span, truncated toward zero, mod 256.
	function automatic logic [CH_W-1:0] hue_in_sector(int unsigned ofs, int unsigned lead,
			int unsigned trail, int unsigned span);
		int unsigned q;
		if (lead >= trail) begin
			q = (HUE_SCALE * (lead - trail)) / span;
			return CH_W'((ofs + q) & 8'hFF);
		end
		q = (HUE_SCALE * (trail - lead)) / span;
		return CH_W'((ofs + 256 - q) & 8'hFF);
	endfunction

	function automatic hsv_t hsv_of(pixel_t px);
		int unsigned r, g, b, hi, lo, span;
		hsv_t res;
		r = px.red;
		g = px.green;
		b = px.blue;
		hi = (r > g) ? r : g;
		hi = (hi > b) ? hi : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		span = hi - lo;
		res = '0;
		res.brightness = CH_W'(hi);
		// black stays at hue 0, sat 0
		if (hi != 0) begin
			res.saturation = CH_W'((SAT_SCALE * span) / hi);
			// gray: no spread, no hue
			if (res.saturation != 0 && span != 0) begin
				// ties: red beats green and blue, green beats blue
				if (hi == r)
					res.hue = hue_in_sector(OFS_RED, g, b, span);
				else if (hi == g)
					res.hue = hue_in_sector(OFS_GREEN, b, r, span);
				else
					res.hue = hue_in_sector(OFS_BLUE, r, g, span);
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Monitors, both sampled at the rising edge with pre-edge values
	// ------------------------------------------------------------------

	// Input side: every accepted pixel queues its expected HSV word.
	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall) begin
			expected_hsv.push_back(hsv_of(pixel));
			pixels_in++;
		end
	end

	// Output side: each accepted word is held against the oldest expectation.
	always @(posedge clk) begin
		hsv_t want;
		if (arst_n && hsv_valid && !hsv_stall) begin
			words_out++;
			if (expected_hsv.size() == 0) begin
				$error("unexpected HSV word: hue %0d sat %0d val %0d",
					hsv.hue, hsv.saturation, hsv.brightness);
				mismatches++;
			end else begin
				want = expected_hsv.pop_front();
				if (hsv.hue !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, hsv.hue);
					mismatches++;
				end
				if (hsv.saturation !== want.saturation) begin
					$error("saturation: expected %0d, got %0d",
						want.saturation, hsv.saturation);
					mismatches++;
				end
				if (hsv.brightness !== want.brightness) begin
					$error("brightness: expected %0d, got %0d",
						want.brightness, hsv.brightness);
					mismatches++;
				end
			end
		end
	end

	// Receiver backpressure, redrawn every cycle from the current profile.
	always @(posedge clk)
		hsv_stall <= ($urandom_range(99) < recv_stall_pct);

	// Hang detector: trips when no word moves on either side for too long.
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic pixel_t rgb(int r, int g, int b);
		pixel_t px;
		px.red   = CH_W'(r);
		px.green = CH_W'(g);
		px.blue  = CH_W'(b);
		return px;
	endfunction

	// Random pixel biased toward the interesting corners of the mapping.
	function automatic pixel_t random_pixel();
		int base;
		case ($urandom_range(5))
			0: begin
				// near gray: channels within two of base, mod 256, so a wrap can give a wide spread
				base = $urandom_range(255);
				return rgb(base, (base + $urandom_range(2)) % 256,
					(base + 256 - $urandom_range(2)) % 256);
			end
			1: begin
				// two channels tied, third random
				base = $urandom_range(255);
				case ($urandom_range(2))
					0: return rgb(base, base, $urandom_range(255));
					1: return rgb(base, $urandom_range(255), base);
					default: return rgb($urandom_range(255), base, base);
				endcase
			end
			2: return rgb($urandom_range(1) * 255, $urandom_range(1) * 255,
				$urandom_range(1) * 255);
			3: return rgb($urandom_range(3), $urandom_range(3), $urandom_range(3));
			default: return rgb($urandom_range(255), $urandom_range(255),
				$urandom_range(255));
		endcase
	endfunction

	// Offer one pixel; returns at the edge where it is taken. Valid stays high
	// on return, so the caller either sends again at once or lowers it.
	task automatic send_pixel(input pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			pixel       <= pixel_t'($urandom);  // junk while idle
			@(posedge clk);
		end
		pixel       <= px;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Black, gray, primaries, ties for the max and hue wrap below zero.
	task automatic test_directed_corners();
		send_pixel(rgb(0, 0, 0));        // black
		send_pixel(rgb(255, 255, 255));  // white: gray at full value
		send_pixel(rgb(128, 128, 128));
		send_pixel(rgb(1, 1, 1));
		send_pixel(rgb(255, 0, 0));
		send_pixel(rgb(0, 255, 0));
		send_pixel(rgb(0, 0, 255));
		send_pixel(rgb(0, 0, 1));        // blue sector, zero difference
		send_pixel(rgb(1, 0, 0));        // smallest nonzero max
		send_pixel(rgb(255, 254, 254));  // saturation of one
		send_pixel(rgb(255, 0, 1));      // red, tiny negative diff
		send_pixel(rgb(255, 0, 255));    // red/blue tie, hue wraps to 213
		send_pixel(rgb(200, 100, 150));  // red, negative diff wraps
		send_pixel(rgb(255, 255, 0));    // red/green tie goes to red
		send_pixel(rgb(0, 200, 200));    // green/blue tie goes to green
		send_pixel(rgb(100, 200, 50));   // green, negative diff
		send_pixel(rgb(50, 200, 100));   // green, positive diff
		send_pixel(rgb(1, 2, 3));        // blue, negative diff
		send_pixel(rgb(3, 2, 255));      // blue, positive diff
		send_pixel(rgb(170, 85, 85));
		pixel_valid <= 1'b0;
	endtask

	task automatic test_random_stream(input int count);
		repeat (count)
			send_pixel(random_pixel());
		pixel_valid <= 1'b0;
	endtask

	// Sender holds off until the pipe is empty, then restarts from cold.
	task automatic test_drain_pause();
		repeat (20)
			send_pixel(random_pixel());
		pixel_valid <= 1'b0;
		while (expected_hsv.size() != 0)
			@(posedge clk);
		repeat (20)
			send_pixel(random_pixel());
		pixel_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sparse output draining: pipe fills and pixel_stall rises
		send_idle_pct  = 12;
		recv_stall_pct = 81;
		test_directed_corners();
		test_random_stream(RANDOM_WORDS);
		test_drain_pause();

		// starved input: bubbles through the divider chain
		send_idle_pct  = 81;
		recv_stall_pct = 12;
		test_random_stream(RANDOM_WORDS);

		// full rate both ways
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_stream(RANDOM_WORDS);

		while (expected_hsv.size() != 0)
			@(posedge clk);
		// catch any stray word after the last expected one
		repeat (2 * PIPE_LATENCY)
			@(posedge clk);

		$display("Converted %0d pixels (corners, ties, grays, random) under three", pixels_in);
		$display("stall/idle profiles plus a full drain; %0d HSV words checked.", words_out);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
